// ----- hw/rtl/scm_pkg.sv -----
// shared types and constants for the sorted change map
package scm_pkg;

    // operation codes carried in the input tuser
    typedef enum logic [1:0] {
        FN_INSERT = 2'd0,
        FN_REMOVE = 2'd1,
        FN_LOOKUP = 2'd2,
        FN_READ   = 2'd3
    } func_t;

    // field widths fixed by the word layout
    localparam int POS_W      = 48;
    localparam int SIG_W      = 6;
    localparam int INDEX_W    = 7;
    localparam int SLOT_W     = 6;
    localparam int COUNT_W    = 7;
    localparam int S_DATA_W   = 72;
    localparam int S_USER_W   = 2;
    localparam int M_DATA_W   = 80;
    localparam int M_USER_W   = 1;
    localparam int CFG_ADDR_W = 1;

    // register indexes on the configuration port
    localparam logic [CFG_ADDR_W-1:0] REG_BASE_NUM = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BASE_DEN = 1'd1;

    // signature limits and reset value of the base signature
    localparam logic [SIG_W-1:0] NUM_MIN    = 6'd1;
    localparam logic [SIG_W-1:0] NUM_MAX    = 6'd32;
    localparam logic [SIG_W-1:0] BASE_RESET = 6'd4;

    // numerator and denominator of one change
    typedef struct packed {
        logic [SIG_W-1:0] num;
        logic [SIG_W-1:0] den;
    } sig_t;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic  capture;
        func_t func;
        logic  ins_shift;
        logic  rem_shift;
    } cell_ctl_t;

    // a 6-bit denominator is valid when it is a power of two (1 to 32)
    function automatic logic den_valid(input logic [SIG_W-1:0] den);
        return (den != '0) && ((den & (den - SIG_W'(1))) == '0);
    endfunction

endpackage

// ----- hw/rtl/sorted_change_map_top.sv -----
// Sorted table of time-signature changes with insert, remove, lookup and read by index.
// Each item has an accept step and an apply step: on accept, every cell of the row compares its
// stored position (or its own index) with the item and registers a flag; in the apply state
// the row shifts by one cell for an insert or remove that passes its checks, while the slot
// and the selected entry are encoded from the edges of the flagged run and written to the output
// register. An item is accepted only while the sequencer is idle, and the apply state waits while
// the previous result is still held at the output. The table needs no clearing pass after reset.
module sorted_change_map_top #(
    parameter int MAX_CHANGES = 64,
    parameter int POS_BITS    = 48
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input words
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // position[47:0], numerator[53:48], denominator[59:54], index[66:60], zero pad
    input  logic [scm_pkg::S_DATA_W-1:0]     s_tdata,
    // func[1:0]
    input  logic [scm_pkg::S_USER_W-1:0]     s_tuser,
    // result words
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // slot[5:0], position_out[53:6], numerator_out[59:54], denominator_out[65:60],
    // entry_count[72:66], zero pad
    output logic [scm_pkg::M_DATA_W-1:0]     m_tdata,
    // status[0]
    output logic [scm_pkg::M_USER_W-1:0]     m_tuser,
    // configuration writes
    input  logic                             cfg_wen,
    input  logic [scm_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [scm_pkg::SIG_W-1:0]        cfg_wdata
);
    import scm_pkg::*;

    localparam int CNT_W = $clog2(MAX_CHANGES + 1);
    localparam int IDX_W = (MAX_CHANGES > 1) ? $clog2(MAX_CHANGES) : 1;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_APPLY = 2'b10
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [SIG_W-1:0]     base_num_reg, base_den_reg;
    func_t                op_reg;
    logic [POS_BITS-1:0]  qpos_reg;
    sig_t                 qsig_reg;
    logic [INDEX_W-1:0]   idx_reg;
    logic                 m_tvalid_reg;
    logic [M_DATA_W-1:0]  m_tdata_reg;
    logic [M_USER_W-1:0]  m_tuser_reg;

    logic                 accept, out_free, apply_go;
    func_t                in_func;
    logic [POS_BITS-1:0]  in_pos;
    cell_ctl_t            ctl;

    logic [POS_BITS-1:0]  cell_pos [MAX_CHANGES];
    sig_t                 cell_sig [MAX_CHANGES];
    logic [POS_BITS-1:0]  lft_pos  [MAX_CHANGES];
    sig_t                 lft_sig  [MAX_CHANGES];
    logic [POS_BITS-1:0]  rgt_pos  [MAX_CHANGES];
    sig_t                 rgt_sig  [MAX_CHANGES];
    logic [MAX_CHANGES-1:0] flags, lft_flag, rgt_flag, first_hit, last_hit;

    logic [IDX_W-1:0]     slot_acc;
    logic [POS_BITS-1:0]  rd_pos;
    sig_t                 rd_sig, hit_sig;
    logic                 ins_ok, idx_ok, commit_ins, commit_rem;
    logic                 res_status;
    logic [SLOT_W-1:0]    res_slot;
    logic [POS_W-1:0]     res_pos;
    sig_t                 res_sig;

    // handshake
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign apply_go = (state_reg == ST_APPLY) && out_free;
    assign in_func  = func_t'(s_tuser[1:0]);
    assign in_pos   = POS_BITS'(s_tdata[POS_W-1:0]);

    // cell control broadcast
    assign ctl.capture   = accept;
    assign ctl.func      = in_func;
    assign ctl.ins_shift = apply_go && commit_ins;
    assign ctl.rem_shift = apply_go && commit_rem;

    // row of cells with neighbour links
    for (genvar gi = 0; gi < MAX_CHANGES; gi++) begin : g_cell
        if (gi == 0) begin : g_left_end
            assign lft_flag[gi] = 1'b1;
            assign lft_pos[gi]  = cell_pos[gi];
            assign lft_sig[gi]  = cell_sig[gi];
        end else begin : g_left
            assign lft_flag[gi] = flags[gi-1];
            assign lft_pos[gi]  = cell_pos[gi-1];
            assign lft_sig[gi]  = cell_sig[gi-1];
        end
        if (gi == MAX_CHANGES - 1) begin : g_right_end
            assign rgt_flag[gi] = 1'b0;
            assign rgt_pos[gi]  = cell_pos[gi];
            assign rgt_sig[gi]  = cell_sig[gi];
        end else begin : g_right
            assign rgt_flag[gi] = flags[gi+1];
            assign rgt_pos[gi]  = cell_pos[gi+1];
            assign rgt_sig[gi]  = cell_sig[gi+1];
        end

        scm_cell #(
            .POS_BITS (POS_BITS),
            .CNT_W    (CNT_W),
            .CELL_IDX (gi)
        ) u_cell (
            .aclk       (aclk),
            .ctl        (ctl),
            .query_pos  (in_pos),
            .query_idx  (s_tdata[66:60]),
            .count      (count_reg),
            .new_pos    (qpos_reg),
            .new_sig    (qsig_reg),
            .left_flag  (lft_flag[gi]),
            .left_pos   (lft_pos[gi]),
            .left_sig   (lft_sig[gi]),
            .right_flag (rgt_flag[gi]),
            .right_pos  (rgt_pos[gi]),
            .right_sig  (rgt_sig[gi]),
            .pos_out    (cell_pos[gi]),
            .sig_out    (cell_sig[gi]),
            .flag_out   (flags[gi]),
            .first_hit  (first_hit[gi]),
            .last_hit   (last_hit[gi])
        );
    end

    // encode slot and select entries from the one-hot run edges
    always_comb begin
        slot_acc = '0;
        rd_pos   = '0;
        rd_sig   = '0;
        hit_sig  = '0;
        for (int i = 0; i < MAX_CHANGES; i++) begin
            if (first_hit[i]) begin
                slot_acc = slot_acc | IDX_W'(i);
                rd_pos   = rd_pos | cell_pos[i];
                rd_sig   = rd_sig | cell_sig[i];
            end
            if (last_hit[i]) begin
                hit_sig = hit_sig | cell_sig[i];
            end
        end
    end

    // field checks
    assign ins_ok = (qsig_reg.num >= NUM_MIN) && (qsig_reg.num <= NUM_MAX)
                    && den_valid(qsig_reg.den) && (32'(count_reg) < MAX_CHANGES);
    assign idx_ok = 32'(idx_reg) < 32'(count_reg);

    // result and count update
    always_comb begin
        res_status = 1'b1;
        res_slot   = '0;
        res_pos    = '0;
        res_sig    = '0;
        count_next = count_reg;
        commit_ins = 1'b0;
        commit_rem = 1'b0;
        unique case (op_reg)
            FN_INSERT: begin
                if (ins_ok) begin
                    res_status = 1'b0;
                    res_slot   = SLOT_W'(slot_acc);
                    count_next = count_reg + CNT_W'(1);
                    commit_ins = 1'b1;
                end
            end
            FN_REMOVE: begin
                if (idx_ok) begin
                    res_status = 1'b0;
                    count_next = count_reg - CNT_W'(1);
                    commit_rem = 1'b1;
                end
            end
            FN_LOOKUP: begin
                res_status = 1'b0;
                if (flags[0]) begin
                    res_sig = hit_sig;
                end else begin
                    res_sig.num = base_num_reg;
                    res_sig.den = base_den_reg;
                end
            end
            FN_READ: begin
                if (idx_ok) begin
                    res_status = 1'b0;
                    res_pos    = POS_W'(rd_pos);
                    res_sig    = rd_sig;
                end
            end
            default: ;
        endcase
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (accept) state_next = ST_APPLY;
            ST_APPLY: if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            base_num_reg <= BASE_RESET;
            base_den_reg <= BASE_RESET;
        end else begin
            state_reg <= state_next;
            if (apply_go) begin
                count_reg    <= count_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_wen) begin
                unique case (cfg_addr)
                    REG_BASE_NUM: base_num_reg <= cfg_wdata;
                    REG_BASE_DEN: base_den_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg       <= in_func;
            qpos_reg     <= in_pos;
            qsig_reg.num <= s_tdata[53:48];
            qsig_reg.den <= s_tdata[59:54];
            idx_reg      <= s_tdata[66:60];
        end
        if (apply_go) begin
            m_tdata_reg <= {7'd0, COUNT_W'(count_next), res_sig.den, res_sig.num,
                            res_pos, res_slot};
            m_tuser_reg <= res_status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // table never holds more than its depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) <= MAX_CHANGES)
        else $error("entry count beyond table depth");

    // the count only moves when an item is applied
    a_count_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |=> $stable(count_reg))
        else $error("entry count changed without an item");

    // an accepted item always reaches the apply cycle next
    a_accept_apply: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_APPLY))
        else $error("accepted item not applied");

    // flags form one leading run, so the table is kept sorted
    a_flag_prefix: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_APPLY) |-> (((flags >> 1) & ~flags) == '0))
        else $error("cell flags are not a leading run");

    // at most one cell opens the run edge
    a_first_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_APPLY) |-> $onehot0(first_hit))
        else $error("more than one first unflagged cell");

endmodule

// ----- hw/rtl/scm_cell.sv -----
// one slot of the change table with its compare flag and neighbour shift
module scm_cell #(
    parameter int POS_BITS = 48,
    parameter int CNT_W    = 7,
    parameter int CELL_IDX = 0
) (
    input  logic                           aclk,
    input  scm_pkg::cell_ctl_t             ctl,
    input  logic [POS_BITS-1:0]            query_pos,
    input  logic [scm_pkg::INDEX_W-1:0]    query_idx,
    input  logic [CNT_W-1:0]               count,
    input  logic [POS_BITS-1:0]            new_pos,
    input  scm_pkg::sig_t                  new_sig,
    input  logic                           left_flag,
    input  logic [POS_BITS-1:0]            left_pos,
    input  scm_pkg::sig_t                  left_sig,
    input  logic                           right_flag,
    input  logic [POS_BITS-1:0]            right_pos,
    input  scm_pkg::sig_t                  right_sig,
    output logic [POS_BITS-1:0]            pos_out,
    output scm_pkg::sig_t                  sig_out,
    output logic                           flag_out,
    output logic                           first_hit,
    output logic                           last_hit
);
    import scm_pkg::*;

    logic [POS_BITS-1:0] pos_reg, pos_next;
    sig_t                sig_reg, sig_next;
    logic                flag_reg, flag_next;
    logic                occupied;

    // slot holds a live change
    assign occupied = 32'(count) > CELL_IDX;

    // flag marks the leading run of cells: below the key, at or below it, or below the index
    always_comb begin
        unique case (ctl.func)
            FN_INSERT: flag_next = occupied && (pos_reg < query_pos);
            FN_LOOKUP: flag_next = occupied && (pos_reg <= query_pos);
            FN_REMOVE,
            FN_READ:   flag_next = CELL_IDX < 32'(query_idx);
            default:   flag_next = 1'b0;
        endcase
    end

    // insert opens a gap at the first unflagged cell, remove pulls from the right
    always_comb begin
        pos_next = pos_reg;
        sig_next = sig_reg;
        if (ctl.ins_shift && !flag_reg) begin
            if (left_flag) begin
                pos_next = new_pos;
                sig_next = new_sig;
            end else begin
                pos_next = left_pos;
                sig_next = left_sig;
            end
        end else if (ctl.rem_shift && !flag_reg) begin
            pos_next = right_pos;
            sig_next = right_sig;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg <= pos_next;
        sig_reg <= sig_next;
        if (ctl.capture) begin
            flag_reg <= flag_next;
        end
    end

    // edges of the flagged run
    assign first_hit = !flag_reg && left_flag;
    assign last_hit  = flag_reg && !right_flag;
    assign pos_out   = pos_reg;
    assign sig_out   = sig_reg;
    assign flag_out  = flag_reg;

endmodule

// ----- tb/sv/tb_sorted_change_map_top.sv -----
// testbench for sorted_change_map_top: directed and random table edits checked against a predictor
module tb_sorted_change_map_top;
    import scm_pkg::*;

    localparam int          TABLE_DEPTH    = 64;
    localparam logic [47:0] POS_MAX        = 48'hFFFF_FFFF_FFFF;
    localparam int          SETTLE_CYCLES  = 8;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          WATCHDOG_LIMIT = 2000;

    // one input word and one result word, unpacked into fields
    typedef struct packed {
        func_t       func;
        logic [47:0] pos;
        logic [5:0]  num;
        logic [5:0]  den;
        logic [6:0]  idx;
    } op_word_t;

    typedef struct packed {
        logic        status;
        logic [5:0]  slot;
        logic [47:0] pos;
        logic [5:0]  num;
        logic [5:0]  den;
        logic [6:0]  count;
    } result_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    // position[47:0], numerator[53:48], denominator[59:54], index[66:60], zero pad
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    // func[1:0]
    logic [S_USER_W-1:0]   s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    // slot[5:0], position_out[53:6], numerator_out[59:54], denominator_out[65:60],
    // entry_count[72:66], zero pad
    logic [M_DATA_W-1:0]   m_tdata;
    // status[0]
    logic [M_USER_W-1:0]   m_tuser;
    logic                  cfg_wen   = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [SIG_W-1:0]      cfg_wdata = '0;

    // predicted table contents and base signature
    logic [47:0] change_pos [TABLE_DEPTH];
    logic [5:0]  change_num [TABLE_DEPTH];
    logic [5:0]  change_den [TABLE_DEPTH];
    int          change_count = 0;
    logic [5:0]  base_num_q   = 6'd4;
    logic [5:0]  base_den_q   = 6'd4;

    result_t     pending_results [$];
    int          error_count    = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          hold_token     = 0;
    int          hold_seen      = 0;
    int          hold_left      = 0;
    int          stall_cycles   = 0;

    sorted_change_map_top #(
        .MAX_CHANGES(TABLE_DEPTH),
        .POS_BITS   (POS_W)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_wen  (cfg_wen),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // apply one operation to the predicted table and return the result it gives
    function automatic result_t apply_change_op(input op_word_t w);
        result_t r;
        int      at;
        int      hit;
        int      i;
        r        = '0;
        r.status = 1'b1;
        case (w.func)
            FN_INSERT: begin
                if (w.num >= 6'd1 && w.num <= 6'd32 && change_count < TABLE_DEPTH &&
                    (w.den == 6'd1 || w.den == 6'd2 || w.den == 6'd4 || w.den == 6'd8 ||
                     w.den == 6'd16 || w.den == 6'd32)) begin
                    // lands before any entry with an equal or larger position
                    at = 0;
                    while (at < change_count && change_pos[at] < w.pos) at++;
                    for (i = change_count; i > at; i--) begin
                        change_pos[i] = change_pos[i-1];
                        change_num[i] = change_num[i-1];
                        change_den[i] = change_den[i-1];
                    end
                    change_pos[at] = w.pos;
                    change_num[at] = w.num;
                    change_den[at] = w.den;
                    change_count++;
                    r.status = 1'b0;
                    r.slot   = 6'(at);
                end
            end
            FN_REMOVE: begin
                if (int'(w.idx) < change_count) begin
                    for (i = int'(w.idx); i + 1 < change_count; i++) begin
                        change_pos[i] = change_pos[i+1];
                        change_num[i] = change_num[i+1];
                        change_den[i] = change_den[i+1];
                    end
                    change_count--;
                    r.status = 1'b0;
                end
            end
            FN_LOOKUP: begin
                // last entry at or before the query, else the base signature
                hit = -1;
                for (i = 0; i < change_count; i++)
                    if (change_pos[i] <= w.pos) hit = i;
                if (hit >= 0) begin
                    r.num = change_num[hit];
                    r.den = change_den[hit];
                end else begin
                    r.num = base_num_q;
                    r.den = base_den_q;
                end
                r.status = 1'b0;
            end
            default: begin
                if (int'(w.idx) < change_count) begin
                    r.pos    = change_pos[w.idx];
                    r.num    = change_num[w.idx];
                    r.den    = change_den[w.idx];
                    r.status = 1'b0;
                end
            end
        endcase
        r.count = 7'(change_count);
        return r;
    endfunction

    function automatic op_word_t make_word(input func_t f, input logic [47:0] p,
                                           input logic [5:0] n, input logic [5:0] d,
                                           input logic [6:0] i);
        op_word_t w;
        w.func = f;
        w.pos  = p;
        w.num  = n;
        w.den  = d;
        w.idx  = i;
        return w;
    endfunction

    // positions: existing entries, a small crowded range, anywhere, or near the top
    function automatic logic [47:0] pick_position();
        logic [47:0] p;
        case ($urandom_range(3))
            0:       p = (change_count != 0) ? change_pos[$urandom_range(change_count - 1)]
                                             : 48'd0;
            1:       p = 48'($urandom_range(255));
            2:       p = {16'($urandom), $urandom};
            default: p = POS_MAX - 48'($urandom_range(3));
        endcase
        return p;
    endfunction

    function automatic logic [6:0] pick_index();
        if (change_count != 0 && $urandom_range(7) != 0)
            return 7'($urandom_range(change_count - 1));
        return 7'($urandom_range(127));
    endfunction

    // mostly well-formed edits and queries, table size hovering around forty
    function automatic op_word_t gen_mixed_word();
        op_word_t w;
        int       pick;
        int       ins_share;
        pick      = $urandom_range(99);
        ins_share = (change_count > 40) ? 15 : 30;
        w = make_word(FN_LOOKUP, pick_position(), 6'($urandom_range(1, 32)),
                      6'(1 << $urandom_range(5)), pick_index());
        if (pick < 10) begin
            w = make_word(func_t'(2'($urandom_range(3))), {16'($urandom), $urandom},
                          6'($urandom), 6'($urandom), 7'($urandom));
        end else if (pick < 10 + ins_share) begin
            w.func = FN_INSERT;
        end else if (pick < 30 + ins_share) begin
            w.func = FN_REMOVE;
        end else if (pick < 55 + ins_share) begin
            if ($urandom_range(1) != 0) w.pos = w.pos - 48'd1;
        end else begin
            w.func = FN_READ;
        end
        return w;
    endfunction

    // offer one word, with random gaps first, and predict once it is taken
    task automatic send_word(input op_word_t w);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= w.func;
        s_tdata  <= {5'd0, w.idx, w.den, w.num, w.pos};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(apply_change_op(w));
    endtask

    // stop offering and wait until every predicted result has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_base(input logic [5:0] num, input logic [5:0] den);
        cfg_wen   <= 1'b1;
        cfg_addr  <= REG_BASE_NUM;
        cfg_wdata <= num;
        @(posedge aclk);
        cfg_addr  <= REG_BASE_DEN;
        cfg_wdata <= den;
        @(posedge aclk);
        cfg_wen    <= 1'b0;
        base_num_q  = num;
        base_den_q  = den;
        @(posedge aclk);
    endtask

    // lookups and index operations on the empty table
    task automatic test_empty_table();
        send_word(make_word(FN_LOOKUP, 48'd0, 6'd0, 6'd0, 7'd0));
        send_word(make_word(FN_LOOKUP, POS_MAX, 6'd0, 6'd0, 7'd0));
        send_word(make_word(FN_READ, 48'd0, 6'd0, 6'd0, 7'd0));
        send_word(make_word(FN_READ, 48'd0, 6'd0, 6'd0, 7'd127));
        send_word(make_word(FN_REMOVE, 48'd0, 6'd0, 6'd0, 7'd0));
    endtask

    // field checks on insert, equal positions, lookups around the entries
    task automatic test_insert_rules();
        send_word(make_word(FN_INSERT, 48'd5, 6'd0, 6'd4, 7'd0));
        send_word(make_word(FN_INSERT, 48'd5, 6'd33, 6'd4, 7'd0));
        send_word(make_word(FN_INSERT, 48'd5, 6'd63, 6'd4, 7'd0));
        send_word(make_word(FN_INSERT, 48'd5, 6'd4, 6'd0, 7'd0));
        send_word(make_word(FN_INSERT, 48'd5, 6'd4, 6'd3, 7'd0));
        send_word(make_word(FN_INSERT, 48'd5, 6'd4, 6'd63, 7'd0));
        send_word(make_word(FN_INSERT, POS_MAX, 6'd32, 6'd32, 7'd127));
        send_word(make_word(FN_INSERT, 48'd1000, 6'd7, 6'd8, 7'd0));
        send_word(make_word(FN_INSERT, 48'd1000, 6'd3, 6'd4, 7'd0));
        send_word(make_word(FN_INSERT, 48'd1000, 6'd5, 6'd16, 7'd0));
        send_word(make_word(FN_LOOKUP, 48'd999, 6'd0, 6'd0, 7'd0));
        send_word(make_word(FN_LOOKUP, 48'd1000, 6'd0, 6'd0, 7'd0));
        send_word(make_word(FN_LOOKUP, POS_MAX - 48'd1, 6'd0, 6'd0, 7'd0));
        send_word(make_word(FN_LOOKUP, POS_MAX, 6'd0, 6'd0, 7'd0));
        send_word(make_word(FN_INSERT, 48'd0, 6'd1, 6'd1, 7'd0));
        send_word(make_word(FN_READ, 48'd0, 6'd0, 6'd0, 7'd4));
        send_word(make_word(FN_READ, 48'd0, 6'd0, 6'd0, 7'd5));
        send_word(make_word(FN_REMOVE, 48'd0, 6'd0, 6'd0, 7'd0));
        send_word(make_word(FN_READ, 48'd0, 6'd0, 6'd0, 7'd0));
        send_word(make_word(FN_LOOKUP, 48'd0, 6'd0, 6'd0, 7'd0));
    endtask

    // fill the table, then push past the end and work at both ends
    task automatic test_full_table();
        while (change_count < TABLE_DEPTH)
            send_word(make_word(FN_INSERT, pick_position(), 6'($urandom_range(1, 32)),
                                6'(1 << $urandom_range(5)), 7'd0));
        send_word(make_word(FN_INSERT, 48'd7, 6'd3, 6'd8, 7'd0));
        send_word(make_word(FN_READ, 48'd0, 6'd0, 6'd0, 7'd63));
        send_word(make_word(FN_READ, 48'd0, 6'd0, 6'd0, 7'd64));
        send_word(make_word(FN_REMOVE, 48'd0, 6'd0, 6'd0, 7'd63));
        send_word(make_word(FN_REMOVE, 48'd0, 6'd0, 6'd0, 7'd0));
        send_word(make_word(FN_LOOKUP, POS_MAX, 6'd0, 6'd0, 7'd0));
    endtask

    task automatic test_mixed_traffic(input int words, input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (words) send_word(gen_mixed_word());
        wait_drained();
    endtask

    // receiver holds off for a long stretch while words keep coming
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_token++;
        repeat (40) send_word(gen_mixed_word());
        wait_drained();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_empty_table();
        test_insert_rules();
        test_full_table();
        wait_drained();
        set_base(6'd32, 6'd32);
        test_mixed_traffic(100, 0, 0);
        set_base(6'd1, 6'd1);
        test_mixed_traffic(100, 61, 0);
        set_base(6'd63, 6'd0);
        test_mixed_traffic(100, 0, 61);
        set_base(6'd17, 6'd8);
        test_mixed_traffic(100, 13, 13);
        test_backpressure();
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // result ready: random stalls, or a counted hold-off when one is asked for
    always @(posedge aclk) begin
        if (hold_seen != hold_token) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic compare_field(input string name, input logic [47:0] want,
                                 input logic [47:0] seen);
        if (want !== seen) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, seen);
        end
    endtask

    // compare each result word with the oldest prediction
    always @(posedge aclk) begin : result_check
        result_t seen;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            seen.status = m_tuser[0];
            seen.slot   = m_tdata[5:0];
            seen.pos    = m_tdata[53:6];
            seen.num    = m_tdata[59:54];
            seen.den    = m_tdata[65:60];
            seen.count  = m_tdata[72:66];
            if (pending_results.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result word, expected none, got %0h", $time, seen);
            end else begin
                want = pending_results.pop_front();
                compare_field("status", 48'(want.status), 48'(seen.status));
                compare_field("slot", 48'(want.slot), 48'(seen.slot));
                compare_field("position_out", want.pos, seen.pos);
                compare_field("numerator_out", 48'(want.num), 48'(seen.num));
                compare_field("denominator_out", 48'(want.den), 48'(seen.den));
                compare_field("entry_count", 48'(want.count), 48'(seen.count));
            end
        end
    end

    // watchdog on cycles in which no word moves on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles, %0d results outstanding",
                     $time, stall_cycles, pending_results.size());
            $display("Test completed with failures");
            $finish;
        end
    end

endmodule

// ----- files.f -----
hw/rtl/scm_pkg.sv
hw/rtl/scm_cell.sv
hw/rtl/sorted_change_map_top.sv
tb/sv/tb_sorted_change_map_top.sv
